@@ rtl/ccc_pkg.sv @@
package ccc_pkg;

	// Session states
	typedef enum logic [2:0] {
		ST_IDLE       = 3'd0,
		ST_PEND_I     = 3'd1,
		ST_OPEN       = 3'd2,
		ST_PEND_U     = 3'd3,
		ST_PEND_T     = 3'd4,
		ST_PEND_E     = 3'd5,
		ST_PEND_B     = 3'd6,
		ST_TERMINATED = 3'd7
	} sess_state_t;

	localparam int CODE_W = 5;
	localparam int ACT_W  = 5;
	localparam int CFG_W  = 16;

	localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd10;

	// Event codes
	localparam logic [CODE_W-1:0] EV_INITIAL_REQUEST   = 5'd0;
	localparam logic [CODE_W-1:0] EV_DIRECT_DEBIT_REQ  = 5'd1;
	localparam logic [CODE_W-1:0] EV_REFUND_REQ        = 5'd2;
	localparam logic [CODE_W-1:0] EV_CHECK_BAL_REQ     = 5'd3;
	localparam logic [CODE_W-1:0] EV_PRICE_ENQ_REQ     = 5'd4;
	localparam logic [CODE_W-1:0] EV_STORED_EVENT_SENT = 5'd5;
	localparam logic [CODE_W-1:0] EV_INITIAL_ANSWER    = 5'd6;
	localparam logic [CODE_W-1:0] EV_GRANT_NO_SESSION  = 5'd7;
	localparam logic [CODE_W-1:0] EV_TERMINATE_SERVICE = 5'd8;
	localparam logic [CODE_W-1:0] EV_GRANT_SERVICE     = 5'd9;
	localparam logic [CODE_W-1:0] EV_SERVICE_TERM      = 5'd10;
	localparam logic [CODE_W-1:0] EV_CHANGE_RATING     = 5'd11;
	localparam logic [CODE_W-1:0] EV_UNITS_ELAPSED     = 5'd12;
	localparam logic [CODE_W-1:0] EV_SENT_UPDATE_REQ   = 5'd13;
	localparam logic [CODE_W-1:0] EV_TERM_REQUEST      = 5'd14;
	localparam logic [CODE_W-1:0] EV_RAR_RECEIVED      = 5'd15;
	localparam logic [CODE_W-1:0] EV_UPDATE_ANSWER     = 5'd16;
	localparam logic [CODE_W-1:0] EV_TCC_EXPIRED       = 5'd17;
	localparam logic [CODE_W-1:0] EV_SUCCESS_TERM_ANS  = 5'd18;
	localparam logic [CODE_W-1:0] EV_TERM_ANSWER       = 5'd19;
	localparam logic [CODE_W-1:0] EV_FAILURE           = 5'd20;
	localparam logic [CODE_W-1:0] EV_DIRECT_DEBIT_ANS  = 5'd21;
	localparam logic [CODE_W-1:0] EV_REFUND_ANS        = 5'd22;
	localparam logic [CODE_W-1:0] EV_CHECK_BAL_ANS     = 5'd23;
	localparam logic [CODE_W-1:0] EV_PRICE_ENQ_ANS     = 5'd24;
	localparam logic [CODE_W-1:0] EV_STORE_REQ_T_FLAG  = 5'd25;
	localparam logic [CODE_W-1:0] EV_STORE_REQ         = 5'd26;
	localparam logic [CODE_W-1:0] EV_SUCCESS_ANSWER    = 5'd27;
	localparam logic [CODE_W-1:0] EV_FAILED_ANSWER     = 5'd28;
	localparam logic [CODE_W-1:0] EV_FAILURE_TO_SEND   = 5'd29;
	localparam logic [CODE_W-1:0] EV_TICK              = 5'd30;
	localparam logic [CODE_W-1:0] EV_EXPIRY            = 5'd30;
	localparam logic [CODE_W-1:0] EV_UNLISTED          = 5'd31;

	// Action routines
	localparam logic [ACT_W-1:0] ACT_NONE             = 5'd0;
	localparam logic [ACT_W-1:0] ACT_INITIAL_REQUEST  = 5'd1;
	localparam logic [ACT_W-1:0] ACT_SUCCESS_ANSWER   = 5'd2;
	localparam logic [ACT_W-1:0] ACT_INITIAL_ANSWER   = 5'd3;
	localparam logic [ACT_W-1:0] ACT_GRANT_SERVICE    = 5'd4;
	localparam logic [ACT_W-1:0] ACT_TERMINATE_SVC    = 5'd5;
	localparam logic [ACT_W-1:0] ACT_TERM_REQUEST     = 5'd6;
	localparam logic [ACT_W-1:0] ACT_TERM_ANSWER      = 5'd7;
	localparam logic [ACT_W-1:0] ACT_TX_EXPIRED       = 5'd8;
	localparam logic [ACT_W-1:0] ACT_SERVICE_TERM     = 5'd9;
	localparam logic [ACT_W-1:0] ACT_CHANGE_RATING    = 5'd10;
	localparam logic [ACT_W-1:0] ACT_UNITS_ELAPSED    = 5'd11;
	localparam logic [ACT_W-1:0] ACT_SEND_UPDATE      = 5'd12;
	localparam logic [ACT_W-1:0] ACT_RAA_AND_UPDATE   = 5'd13;
	localparam logic [ACT_W-1:0] ACT_UPDATE_ANSWER    = 5'd14;
	localparam logic [ACT_W-1:0] ACT_TCC_EXPIRED      = 5'd15;
	localparam logic [ACT_W-1:0] ACT_RAR_RECEIVED     = 5'd16;
	localparam logic [ACT_W-1:0] ACT_DIRECT_DEBIT_REQ = 5'd17;
	localparam logic [ACT_W-1:0] ACT_DIRECT_DEBIT_ANS = 5'd18;
	localparam logic [ACT_W-1:0] ACT_REFUND_REQ       = 5'd19;
	localparam logic [ACT_W-1:0] ACT_REFUND_ANS       = 5'd20;
	localparam logic [ACT_W-1:0] ACT_CHECK_BAL_REQ    = 5'd21;
	localparam logic [ACT_W-1:0] ACT_CHECK_BAL_ANS    = 5'd22;
	localparam logic [ACT_W-1:0] ACT_PRICE_ENQ_REQ    = 5'd23;
	localparam logic [ACT_W-1:0] ACT_PRICE_ENQ_ANS    = 5'd24;
	localparam logic [ACT_W-1:0] ACT_SERVICE_ERROR    = 5'd25;
	localparam logic [ACT_W-1:0] ACT_STORE_REQ_T_FLAG = 5'd26;
	localparam logic [ACT_W-1:0] ACT_STORE_REQ        = 5'd27;
	localparam logic [ACT_W-1:0] ACT_FAILED_ANSWER    = 5'd28;
	localparam logic [ACT_W-1:0] ACT_FAILURE_TO_SEND  = 5'd29;

	// One transition table entry
	typedef struct packed {
		logic             hit;
		sess_state_t      nxt;
		logic [ACT_W-1:0] act;
	} tbl_entry_t;

	// Result of one step
	typedef struct packed {
		sess_state_t      state;
		logic [ACT_W-1:0] act;
		logic             req;
		logic             wild;
		logic             fired;
	} step_res_t;

	function automatic tbl_entry_t ent(sess_state_t nxt, logic [ACT_W-1:0] act);
		tbl_entry_t e;
		e.hit = 1'b1;
		e.nxt = nxt;
		e.act = act;
		return e;
	endfunction

	// Transition table; a miss has hit low
	function automatic tbl_entry_t tbl_lookup(sess_state_t st, logic [CODE_W-1:0] ev);
		tbl_entry_t e;
		e = '{hit: 1'b0, nxt: ST_TERMINATED, act: ACT_NONE};
		unique case (st)
			ST_IDLE: begin
				unique case (ev)
					EV_INITIAL_REQUEST:   e = ent(ST_PEND_I, ACT_INITIAL_REQUEST);
					EV_DIRECT_DEBIT_REQ:  e = ent(ST_PEND_E, ACT_DIRECT_DEBIT_REQ);
					EV_REFUND_REQ:        e = ent(ST_PEND_E, ACT_REFUND_REQ);
					EV_CHECK_BAL_REQ:     e = ent(ST_PEND_E, ACT_CHECK_BAL_REQ);
					EV_PRICE_ENQ_REQ:     e = ent(ST_PEND_E, ACT_PRICE_ENQ_REQ);
					EV_STORED_EVENT_SENT: e = ent(ST_PEND_B, ACT_NONE);
					EV_INITIAL_ANSWER:    e = ent(ST_IDLE, ACT_NONE);
					default: ;
				endcase
			end
			ST_PEND_I: begin
				unique case (ev)
					EV_INITIAL_ANSWER:    e = ent(ST_OPEN, ACT_INITIAL_ANSWER);
					EV_GRANT_NO_SESSION:  e = ent(ST_IDLE, ACT_GRANT_SERVICE);
					EV_TERMINATE_SERVICE: e = ent(ST_IDLE, ACT_TERMINATE_SVC);
					EV_EXPIRY:            e = ent(ST_PEND_I, ACT_TX_EXPIRED);
					EV_GRANT_SERVICE:     e = ent(ST_PEND_I, ACT_GRANT_SERVICE);
					EV_SERVICE_TERM:      e = ent(ST_PEND_I, ACT_SERVICE_TERM);
					EV_CHANGE_RATING:     e = ent(ST_PEND_I, ACT_CHANGE_RATING);
					default: ;
				endcase
			end
			ST_OPEN: begin
				unique case (ev)
					EV_UNITS_ELAPSED:   e = ent(ST_OPEN, ACT_UNITS_ELAPSED);
					EV_SENT_UPDATE_REQ: e = ent(ST_PEND_U, ACT_NONE);
					EV_TERM_REQUEST:    e = ent(ST_PEND_T, ACT_TERM_REQUEST);
					EV_CHANGE_RATING:   e = ent(ST_PEND_U, ACT_SEND_UPDATE);
					EV_SERVICE_TERM:    e = ent(ST_PEND_T, ACT_NONE);
					EV_RAR_RECEIVED:    e = ent(ST_PEND_U, ACT_RAA_AND_UPDATE);
					default: ;
				endcase
			end
			ST_PEND_U: begin
				unique case (ev)
					EV_UPDATE_ANSWER:     e = ent(ST_OPEN, ACT_UPDATE_ANSWER);
					EV_GRANT_NO_SESSION:  e = ent(ST_IDLE, ACT_GRANT_SERVICE);
					EV_TERMINATE_SERVICE: e = ent(ST_IDLE, ACT_TERMINATE_SVC);
					EV_TCC_EXPIRED:       e = ent(ST_PEND_U, ACT_TCC_EXPIRED);
					EV_GRANT_SERVICE:     e = ent(ST_PEND_U, ACT_GRANT_SERVICE);
					EV_SERVICE_TERM:      e = ent(ST_PEND_U, ACT_SERVICE_TERM);
					EV_CHANGE_RATING:     e = ent(ST_PEND_U, ACT_CHANGE_RATING);
					EV_RAR_RECEIVED:      e = ent(ST_PEND_U, ACT_RAR_RECEIVED);
					default: ;
				endcase
			end
			ST_PEND_T: begin
				unique case (ev)
					EV_SUCCESS_TERM_ANS: e = ent(ST_IDLE, ACT_NONE);
					EV_TERM_ANSWER:      e = ent(ST_IDLE, ACT_TERM_ANSWER);
					EV_FAILURE:          e = ent(ST_IDLE, ACT_NONE);
					EV_CHANGE_RATING:    e = ent(ST_PEND_T, ACT_NONE);
					default: ;
				endcase
			end
			ST_PEND_E: begin
				unique case (ev)
					EV_DIRECT_DEBIT_ANS:  e = ent(ST_IDLE, ACT_DIRECT_DEBIT_ANS);
					EV_REFUND_ANS:        e = ent(ST_IDLE, ACT_REFUND_ANS);
					EV_CHECK_BAL_ANS:     e = ent(ST_IDLE, ACT_CHECK_BAL_ANS);
					EV_PRICE_ENQ_ANS:     e = ent(ST_IDLE, ACT_PRICE_ENQ_ANS);
					EV_FAILURE:           e = ent(ST_IDLE, ACT_SERVICE_ERROR);
					EV_TERMINATE_SERVICE: e = ent(ST_IDLE, ACT_TERMINATE_SVC);
					EV_GRANT_SERVICE:     e = ent(ST_IDLE, ACT_GRANT_SERVICE);
					EV_TCC_EXPIRED:       e = ent(ST_PEND_E, ACT_TCC_EXPIRED);
					EV_STORE_REQ_T_FLAG:  e = ent(ST_IDLE, ACT_STORE_REQ_T_FLAG);
					EV_STORE_REQ:         e = ent(ST_IDLE, ACT_STORE_REQ);
					default: ;
				endcase
			end
			ST_PEND_B: begin
				unique case (ev)
					EV_SUCCESS_ANSWER:  e = ent(ST_IDLE, ACT_SUCCESS_ANSWER);
					EV_FAILED_ANSWER:   e = ent(ST_IDLE, ACT_FAILED_ANSWER);
					EV_FAILURE_TO_SEND: e = ent(ST_IDLE, ACT_FAILURE_TO_SEND);
					default: ;
				endcase
			end
			default: ;
		endcase
		return e;
	endfunction

	// Actions that send a credit control request
	function automatic logic sends_request(logic [ACT_W-1:0] act);
		return (act == ACT_INITIAL_REQUEST) || (act == ACT_TERM_REQUEST) ||
			(act == ACT_DIRECT_DEBIT_REQ) || (act == ACT_REFUND_REQ) ||
			(act == ACT_CHECK_BAL_REQ) || (act == ACT_PRICE_ENQ_REQ);
	endfunction

endpackage

@@ rtl/credit_control_client_session_fsm.sv @@
// Credit control client session machine. Each accepted item is an event code
// (0..29 table events, 30 tick, 31 unlisted) and gives exactly one result:
// the new session state, the action routine, a request-sent flag, a wildcard
// flag and a timer-expired flag. The block takes one item per cycle while the
// output is not stalled; an item is held in the input register, then the table
// lookup and timer update run in one pass into the result register, which
// presents the result. The session state and answer timer live in flip-flops
// next to the result register. The answer timeout register may be written only
// while no item is in flight.
module credit_control_client_session_fsm #(
	parameter int TIMER_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [ccc_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ccc_pkg::CODE_W-1:0]  event_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  session_state,
	output logic [ccc_pkg::ACT_W-1:0]   action_taken,
	output logic                        request_sent,
	output logic                        wildcard_hit,
	output logic                        timer_fired
);
	import ccc_pkg::*;

	localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

	logic [CFG_W-1:0]      timeout_q;
	logic                  valid_s1;
	logic [CODE_W-1:0]     code_s1;
	logic                  out_valid_q;
	step_res_t             res_q;
	sess_state_t           state_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic                  armed_q;

	sess_state_t           state_nxt;
	logic [TIMER_BITS-1:0] timer_nxt;
	logic                  armed_nxt;
	step_res_t             res_w;
	logic [32:0]           load_ext;
	logic [32:0]           load_sat;
	logic [TIMER_BITS-1:0] timer_load;
	logic                  out_free;
	logic                  adv;

	// Saturate the timeout to the timer width
	assign load_ext   = {17'b0, timeout_q};
	assign load_sat   = (load_ext > TIMER_MAX) ? TIMER_MAX : load_ext;
	assign timer_load = load_sat[TIMER_BITS-1:0];

	// Handshake: the input register advances when the result register frees up
	assign out_free  = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign out_valid = out_valid_q;

	ccc_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.state_cur (state_q),
		.timer_cur (timer_q),
		.armed_cur (armed_q),
		.code      (code_s1),
		.timer_load(timer_load),
		.state_nxt (state_nxt),
		.timer_nxt (timer_nxt),
		.armed_nxt (armed_nxt),
		.res       (res_w)
	);

	// Hold control state, timer and the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= ST_IDLE;
			timer_q     <= '0;
			armed_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (adv) begin
				state_q <= state_nxt;
				timer_q <= timer_nxt;
				armed_q <= armed_nxt;
			end
		end
	end

	// Capture payload into the input and result registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			code_s1 <= event_code;
		end
		if (adv) begin
			res_q <= res_w;
		end
	end

	assign session_state = res_q.state;
	assign action_taken  = res_q.act;
	assign request_sent  = res_q.req;
	assign wildcard_hit  = res_q.wild;
	assign timer_fired   = res_q.fired;

endmodule

@@ rtl/ccc_step.sv @@
module ccc_step #(
	parameter int TIMER_BITS = 16
) (
	input  ccc_pkg::sess_state_t      state_cur,
	input  logic [TIMER_BITS-1:0]     timer_cur,
	input  logic                      armed_cur,
	input  logic [ccc_pkg::CODE_W-1:0] code,
	input  logic [TIMER_BITS-1:0]     timer_load,
	output ccc_pkg::sess_state_t      state_nxt,
	output logic [TIMER_BITS-1:0]     timer_nxt,
	output logic                      armed_nxt,
	output ccc_pkg::step_res_t        res
);
	import ccc_pkg::*;

	tbl_entry_t        ent_w;
	logic [CODE_W-1:0] ev_w;
	logic              apply_w;
	logic [ACT_W-1:0]  act_w;
	logic              wild_w;
	logic              fired_w;

	// Pick the event to apply: a code, or the expiry event on timer run-out
	always_comb begin
		ev_w    = code;
		apply_w = 1'b0;
		fired_w = 1'b0;
		if (code == EV_TICK) begin
			ev_w = EV_EXPIRY;
			if (armed_cur && (timer_cur <= TIMER_BITS'(1))) begin
				apply_w = 1'b1;
				fired_w = 1'b1;
			end
		end else if (code != EV_UNLISTED) begin
			apply_w = 1'b1;
		end
	end

	assign ent_w = tbl_lookup(state_cur, ev_w);

	// Advance session state and timer
	always_comb begin
		state_nxt = state_cur;
		timer_nxt = timer_cur;
		armed_nxt = armed_cur;
		act_w     = ACT_NONE;
		wild_w    = 1'b0;
		if (code == EV_TICK && armed_cur) begin
			if (fired_w) begin
				timer_nxt = '0;
				armed_nxt = 1'b0;
			end else begin
				timer_nxt = timer_cur - TIMER_BITS'(1);
			end
		end
		if (state_cur != ST_TERMINATED) begin
			if (code == EV_UNLISTED) begin
				state_nxt = ST_TERMINATED;
				wild_w    = 1'b1;
			end else if (apply_w) begin
				if (!ent_w.hit) begin
					state_nxt = ST_TERMINATED;
					wild_w    = 1'b1;
				end else begin
					state_nxt = ent_w.nxt;
					act_w     = ent_w.act;
					if (ent_w.act == ACT_INITIAL_REQUEST) begin
						timer_nxt = timer_load;
						armed_nxt = 1'b1;
					end else if (ent_w.act == ACT_INITIAL_ANSWER) begin
						armed_nxt = 1'b0;
					end
				end
			end
		end
	end

	assign res.state = state_nxt;
	assign res.act   = act_w;
	assign res.req   = sends_request(act_w);
	assign res.wild  = wild_w;
	assign res.fired = fired_w;

endmodule

@@ rtl/ccc_checker.sv @@
module ccc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [2:0]                 session_state,
	input logic [ccc_pkg::ACT_W-1:0]  action_taken,
	input logic                       request_sent,
	input logic                       wildcard_hit,
	input logic                       timer_fired
);
	import ccc_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Drop to terminated on a wildcard hit
	a_wild_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wildcard_hit |-> session_state == ST_TERMINATED
			&& action_taken == ACT_NONE)
		else $error("wildcard hit without terminated state");

	// Flag a request only for request actions
	a_req_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_sent |-> action_taken == ACT_INITIAL_REQUEST
			|| action_taken == ACT_TERM_REQUEST
			|| action_taken == ACT_DIRECT_DEBIT_REQ
			|| action_taken == ACT_REFUND_REQ
			|| action_taken == ACT_CHECK_BAL_REQ
			|| action_taken == ACT_PRICE_ENQ_REQ)
		else $error("request flag on a non-request action");

	// Expiry acts only in pending initial
	a_fire_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timer_fired && action_taken != ACT_NONE
			|-> action_taken == ACT_TX_EXPIRED && session_state == ST_PEND_I)
		else $error("expiry action outside pending initial");

endmodule

bind credit_control_client_session_fsm ccc_checker u_ccc_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import ccc_pkg::*;

	// One entry of the session table as the checker sees it
	typedef struct packed {
		logic             listed;
		sess_state_t      to;
		logic [ACT_W-1:0] act;
	} hop_t;

	// One row of the opening sequence; want is used only where typed is set
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              typed;
		step_res_t         want;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;
	logic              in_valid;
	logic              in_stall;
	logic [CODE_W-1:0] event_code;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        session_state;
	logic [ACT_W-1:0]  action_taken;
	logic              request_sent;
	logic              wildcard_hit;
	logic              timer_fired;

	// Session copy kept by the checker
	sess_state_t       sess;
	logic [15:0]       tmr_left;
	logic              tmr_armed;
	logic [CFG_W-1:0]  answer_ticks;

	step_res_t         awaited_steps [$];
	dir_row_t          dir_rows [25];
	int                fail_count = 0;
	logic              idle_gaps;
	logic              stall_gaps;
	int                hold_cycles;

	credit_control_client_session_fsm DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.event_code   (event_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.session_state(session_state),
		.action_taken (action_taken),
		.request_sent (request_sent),
		.wildcard_hit (wildcard_hit),
		.timer_fired  (timer_fired)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic hop_t leads_to(sess_state_t to, logic [ACT_W-1:0] act);
		hop_t h;
		h.listed = 1'b1;
		h.to = to;
		h.act = act;
		return h;
	endfunction

	// Look up the next state and action for a listed event
	function automatic hop_t table_hop(sess_state_t st, logic [CODE_W-1:0] ev);
		hop_t h;
		h = '{listed: 1'b0, to: ST_TERMINATED, act: ACT_NONE};
		case ({st, ev})
			{ST_IDLE, EV_INITIAL_REQUEST}:     h = leads_to(ST_PEND_I, ACT_INITIAL_REQUEST);
			{ST_IDLE, EV_DIRECT_DEBIT_REQ}:    h = leads_to(ST_PEND_E, ACT_DIRECT_DEBIT_REQ);
			{ST_IDLE, EV_REFUND_REQ}:          h = leads_to(ST_PEND_E, ACT_REFUND_REQ);
			{ST_IDLE, EV_CHECK_BAL_REQ}:       h = leads_to(ST_PEND_E, ACT_CHECK_BAL_REQ);
			{ST_IDLE, EV_PRICE_ENQ_REQ}:       h = leads_to(ST_PEND_E, ACT_PRICE_ENQ_REQ);
			{ST_IDLE, EV_STORED_EVENT_SENT}:   h = leads_to(ST_PEND_B, ACT_NONE);
			{ST_IDLE, EV_INITIAL_ANSWER}:      h = leads_to(ST_IDLE, ACT_NONE);
			{ST_PEND_I, EV_INITIAL_ANSWER}:    h = leads_to(ST_OPEN, ACT_INITIAL_ANSWER);
			{ST_PEND_I, EV_GRANT_NO_SESSION}:  h = leads_to(ST_IDLE, ACT_GRANT_SERVICE);
			{ST_PEND_I, EV_TERMINATE_SERVICE}: h = leads_to(ST_IDLE, ACT_TERMINATE_SVC);
			{ST_PEND_I, EV_EXPIRY}:            h = leads_to(ST_PEND_I, ACT_TX_EXPIRED);
			{ST_PEND_I, EV_GRANT_SERVICE}:     h = leads_to(ST_PEND_I, ACT_GRANT_SERVICE);
			{ST_PEND_I, EV_SERVICE_TERM}:      h = leads_to(ST_PEND_I, ACT_SERVICE_TERM);
			{ST_PEND_I, EV_CHANGE_RATING}:     h = leads_to(ST_PEND_I, ACT_CHANGE_RATING);
			{ST_OPEN, EV_UNITS_ELAPSED}:       h = leads_to(ST_OPEN, ACT_UNITS_ELAPSED);
			{ST_OPEN, EV_SENT_UPDATE_REQ}:     h = leads_to(ST_PEND_U, ACT_NONE);
			{ST_OPEN, EV_TERM_REQUEST}:        h = leads_to(ST_PEND_T, ACT_TERM_REQUEST);
			{ST_OPEN, EV_CHANGE_RATING}:       h = leads_to(ST_PEND_U, ACT_SEND_UPDATE);
			{ST_OPEN, EV_SERVICE_TERM}:        h = leads_to(ST_PEND_T, ACT_NONE);
			{ST_OPEN, EV_RAR_RECEIVED}:        h = leads_to(ST_PEND_U, ACT_RAA_AND_UPDATE);
			{ST_PEND_U, EV_UPDATE_ANSWER}:     h = leads_to(ST_OPEN, ACT_UPDATE_ANSWER);
			{ST_PEND_U, EV_GRANT_NO_SESSION}:  h = leads_to(ST_IDLE, ACT_GRANT_SERVICE);
			{ST_PEND_U, EV_TERMINATE_SERVICE}: h = leads_to(ST_IDLE, ACT_TERMINATE_SVC);
			{ST_PEND_U, EV_TCC_EXPIRED}:       h = leads_to(ST_PEND_U, ACT_TCC_EXPIRED);
			{ST_PEND_U, EV_GRANT_SERVICE}:     h = leads_to(ST_PEND_U, ACT_GRANT_SERVICE);
			{ST_PEND_U, EV_SERVICE_TERM}:      h = leads_to(ST_PEND_U, ACT_SERVICE_TERM);
			{ST_PEND_U, EV_CHANGE_RATING}:     h = leads_to(ST_PEND_U, ACT_CHANGE_RATING);
			{ST_PEND_U, EV_RAR_RECEIVED}:      h = leads_to(ST_PEND_U, ACT_RAR_RECEIVED);
			{ST_PEND_T, EV_SUCCESS_TERM_ANS}:  h = leads_to(ST_IDLE, ACT_NONE);
			{ST_PEND_T, EV_TERM_ANSWER}:       h = leads_to(ST_IDLE, ACT_TERM_ANSWER);
			{ST_PEND_T, EV_FAILURE}:           h = leads_to(ST_IDLE, ACT_NONE);
			{ST_PEND_T, EV_CHANGE_RATING}:     h = leads_to(ST_PEND_T, ACT_NONE);
			{ST_PEND_E, EV_DIRECT_DEBIT_ANS}:  h = leads_to(ST_IDLE, ACT_DIRECT_DEBIT_ANS);
			{ST_PEND_E, EV_REFUND_ANS}:        h = leads_to(ST_IDLE, ACT_REFUND_ANS);
			{ST_PEND_E, EV_CHECK_BAL_ANS}:     h = leads_to(ST_IDLE, ACT_CHECK_BAL_ANS);
			{ST_PEND_E, EV_PRICE_ENQ_ANS}:     h = leads_to(ST_IDLE, ACT_PRICE_ENQ_ANS);
			{ST_PEND_E, EV_FAILURE}:           h = leads_to(ST_IDLE, ACT_SERVICE_ERROR);
			{ST_PEND_E, EV_TERMINATE_SERVICE}: h = leads_to(ST_IDLE, ACT_TERMINATE_SVC);
			{ST_PEND_E, EV_GRANT_SERVICE}:     h = leads_to(ST_IDLE, ACT_GRANT_SERVICE);
			{ST_PEND_E, EV_TCC_EXPIRED}:       h = leads_to(ST_PEND_E, ACT_TCC_EXPIRED);
			{ST_PEND_E, EV_STORE_REQ_T_FLAG}:  h = leads_to(ST_IDLE, ACT_STORE_REQ_T_FLAG);
			{ST_PEND_E, EV_STORE_REQ}:         h = leads_to(ST_IDLE, ACT_STORE_REQ);
			{ST_PEND_B, EV_SUCCESS_ANSWER}:    h = leads_to(ST_IDLE, ACT_SUCCESS_ANSWER);
			{ST_PEND_B, EV_FAILED_ANSWER}:     h = leads_to(ST_IDLE, ACT_FAILED_ANSWER);
			{ST_PEND_B, EV_FAILURE_TO_SEND}:   h = leads_to(ST_IDLE, ACT_FAILURE_TO_SEND);
			default: ;
		endcase
		return h;
	endfunction

	// Advance the session copy by one item and return the step it reports
	function automatic step_res_t session_step(logic [CODE_W-1:0] code);
		step_res_t r;
		hop_t h;
		logic run_table;
		logic [CODE_W-1:0] ev;
		r = '{state: sess, act: ACT_NONE, req: 1'b0, wild: 1'b0, fired: 1'b0};
		run_table = 1'b0;
		ev = code;
		if (code == EV_TICK) begin
			if (tmr_armed) begin
				if (tmr_left <= 16'd1) begin
					tmr_left = '0;
					tmr_armed = 1'b0;
					r.fired = 1'b1;
					run_table = 1'b1;
					ev = EV_EXPIRY;
				end else begin
					tmr_left = tmr_left - 16'd1;
				end
			end
		end else if (code == EV_UNLISTED) begin
			if (sess != ST_TERMINATED) begin
				sess = ST_TERMINATED;
				r.wild = 1'b1;
			end
		end else begin
			run_table = 1'b1;
		end
		// terminated swallows every event, expiry included
		if (run_table && sess != ST_TERMINATED) begin
			h = table_hop(sess, ev);
			if (!h.listed) begin
				sess = ST_TERMINATED;
				r.wild = 1'b1;
			end else begin
				sess = h.to;
				r.act = h.act;
				if (h.act == ACT_INITIAL_REQUEST) begin
					tmr_left = answer_ticks;
					tmr_armed = 1'b1;
				end else if (h.act == ACT_INITIAL_ANSWER) begin
					tmr_armed = 1'b0;
				end
			end
		end
		r.state = sess;
		r.req = (r.act == ACT_INITIAL_REQUEST) || (r.act == ACT_TERM_REQUEST) ||
			(r.act == ACT_DIRECT_DEBIT_REQ) || (r.act == ACT_REFUND_REQ) ||
			(r.act == ACT_CHECK_BAL_REQ) || (r.act == ACT_PRICE_ENQ_REQ);
		return r;
	endfunction

	// Pick an event the current state lists, or a tick that cannot kill the session
	function automatic logic [CODE_W-1:0] pick_live_code(int tick_pct);
		logic [CODE_W-1:0] c;
		hop_t h;
		logic tick_safe;
		tick_safe = !(tmr_armed && tmr_left <= 16'd1 && sess != ST_PEND_I);
		if (tick_safe && $urandom_range(99) < tick_pct)
			return EV_TICK;
		do begin
			c = CODE_W'($urandom_range(29));
			h = table_hop(sess, c);
		end while (!h.listed);
		return c;
	endfunction

	// Offer one item, hold it until taken, then record what it should produce
	task automatic offer_event(input logic [CODE_W-1:0] code, input logic typed,
			input step_res_t typed_res);
		step_res_t r;
		@(negedge clk);
		while (idle_gaps && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		event_code <= code;
		do @(posedge clk); while (in_stall);
		r = session_step(code);
		awaited_steps.push_back(typed ? typed_res : r);
	endtask

	// Drop valid and wait for every outstanding step to come back
	task automatic settle_session();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_steps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [CFG_W-1:0] ticks);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ticks;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		answer_ticks = ticks;
	endtask

	task automatic report_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	// Stall the output at random, or hold it off for a counted stretch
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= stall_gaps && ($urandom_range(99) < 8);
			end
		end
	end

	// Compare each taken result with the oldest awaited step
	always @(posedge clk) begin : watch_results
		step_res_t want;
		if (out_valid && !out_stall) begin
			if (awaited_steps.size() == 0) begin
				$display("%0t: unexpected result, expected none, got state %0d action %0d",
					$time, session_state, action_taken);
				fail_count++;
			end else begin
				want = awaited_steps.pop_front();
				report_field("session_state", int'(want.state), int'(session_state));
				report_field("action_taken", int'(want.act), int'(action_taken));
				report_field("request_sent", int'(want.req), int'(request_sent));
				report_field("wildcard_hit", int'(want.wild), int'(wildcard_hit));
				report_field("timer_fired", int'(want.fired), int'(timer_fired));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : run_session
		logic [CODE_W-1:0] c;
		hop_t h;
		int n;

		arst_n = 1'b0;
		in_valid = 1'b0;
		event_code = EV_INITIAL_REQUEST;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		sess = ST_IDLE;
		tmr_left = '0;
		tmr_armed = 1'b0;
		answer_ticks = TIMEOUT_RESET;
		idle_gaps = 1'b1;
		stall_gaps = 1'b1;
		hold_cycles = 0;

		// Opening walk through every live state at the reset timeout
		dir_rows[0]  = '{EV_TICK, 1'b1, '{ST_IDLE, ACT_NONE, 1'b0, 1'b0, 1'b0}};
		dir_rows[1]  = '{EV_INITIAL_ANSWER, 1'b1, '{ST_IDLE, ACT_NONE, 1'b0, 1'b0, 1'b0}};
		dir_rows[2]  = '{EV_INITIAL_REQUEST, 1'b1,
			'{ST_PEND_I, ACT_INITIAL_REQUEST, 1'b1, 1'b0, 1'b0}};
		dir_rows[3]  = '{EV_TICK, 1'b1, '{ST_PEND_I, ACT_NONE, 1'b0, 1'b0, 1'b0}};
		dir_rows[4]  = '{EV_GRANT_SERVICE, 1'b0, '0};
		dir_rows[5]  = '{EV_SERVICE_TERM, 1'b0, '0};
		dir_rows[6]  = '{EV_CHANGE_RATING, 1'b0, '0};
		// leave the timer running into idle, then re-arm it
		dir_rows[7]  = '{EV_GRANT_NO_SESSION, 1'b0, '0};
		dir_rows[8]  = '{EV_TICK, 1'b0, '0};
		dir_rows[9]  = '{EV_INITIAL_REQUEST, 1'b0, '0};
		dir_rows[10] = '{EV_INITIAL_ANSWER, 1'b0, '0};
		dir_rows[11] = '{EV_TICK, 1'b1, '{ST_OPEN, ACT_NONE, 1'b0, 1'b0, 1'b0}};
		dir_rows[12] = '{EV_UNITS_ELAPSED, 1'b0, '0};
		dir_rows[13] = '{EV_CHANGE_RATING, 1'b0, '0};
		dir_rows[14] = '{EV_TCC_EXPIRED, 1'b0, '0};
		dir_rows[15] = '{EV_RAR_RECEIVED, 1'b0, '0};
		dir_rows[16] = '{EV_UPDATE_ANSWER, 1'b0, '0};
		dir_rows[17] = '{EV_SERVICE_TERM, 1'b0, '0};
		dir_rows[18] = '{EV_CHANGE_RATING, 1'b0, '0};
		dir_rows[19] = '{EV_SUCCESS_TERM_ANS, 1'b0, '0};
		dir_rows[20] = '{EV_DIRECT_DEBIT_REQ, 1'b0, '0};
		dir_rows[21] = '{EV_TCC_EXPIRED, 1'b0, '0};
		dir_rows[22] = '{EV_STORE_REQ_T_FLAG, 1'b0, '0};
		dir_rows[23] = '{EV_STORED_EVENT_SENT, 1'b0, '0};
		dir_rows[24] = '{EV_SUCCESS_ANSWER, 1'b0, '0};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < 25; n++)
			offer_event(dir_rows[n].code, dir_rows[n].typed, dir_rows[n].want);
		settle_session();

		// Timeout of one: expiry on the first tick
		write_timeout(16'd1);
		for (n = 0; n < 100; n++)
			offer_event(pick_live_code(25), 1'b0, '0);
		settle_session();

		// Zero timeout, no idling on either side
		idle_gaps = 1'b0;
		stall_gaps = 1'b0;
		write_timeout(16'd0);
		for (n = 0; n < 80; n++)
			offer_event(pick_live_code(25), 1'b0, '0);
		settle_session();
		idle_gaps = 1'b1;
		stall_gaps = 1'b1;

		// Longest timeout: reach pend_initial and tick it without running out
		write_timeout(16'hFFFF);
		for (n = 0; n < 40; n++) begin
			if (sess == ST_PEND_I && tmr_armed)
				c = EV_TICK;
			else
				c = pick_live_code(10);
			offer_event(c, 1'b0, '0);
		end
		settle_session();

		// Mid timeout with a long output hold-off while items keep coming
		write_timeout(16'd5);
		hold_cycles = 80;
		for (n = 0; n < 250; n++)
			offer_event(pick_live_code(35), 1'b0, '0);
		settle_session();

		// Kill the session with the timer armed, then throw noise at it
		write_timeout(16'd2);
		while (sess != ST_PEND_I)
			offer_event(pick_live_code(20), 1'b0, '0);
		case ($urandom_range(2))
			0: offer_event(EV_UNLISTED, 1'b1,
				'{ST_TERMINATED, ACT_NONE, 1'b0, 1'b1, 1'b0});
			1: begin
				do begin
					c = CODE_W'($urandom_range(29));
					h = table_hop(ST_PEND_I, c);
				end while (h.listed);
				offer_event(c, 1'b0, '0);
			end
			default: offer_event(EV_GRANT_NO_SESSION, 1'b0, '0);
		endcase
		offer_event(EV_TICK, 1'b0, '0);
		offer_event(EV_TICK, 1'b0, '0);
		for (n = 0; n < 40; n++)
			offer_event(CODE_W'($urandom_range(31)), 1'b0, '0);
		offer_event(EV_UNLISTED, 1'b1, '{ST_TERMINATED, ACT_NONE, 1'b0, 1'b0, 1'b0});
		settle_session();

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ccc_pkg.sv
rtl/ccc_step.sv
rtl/credit_control_client_session_fsm.sv
rtl/ccc_checker.sv
sim/tb.sv
